// File: rtl/kmpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmpp_pkg: shared types and constants
// Payload structs, configuration indexes and command/status bundles.
// ----------------------------------------------------------------------------
package kmpp_pkg;
	localparam int MaxTrianglesDefault = 4096;
	localparam int MaxLabelsDefault    = 64;
	localparam int CoordW = 16;
	localparam int DistW  = 17;
	localparam int SumW   = 48;
	localparam int LabelW = 6;
	localparam int IdxW   = 12;

	localparam logic [2:0] CfgNormalX = 3'd0;
	localparam logic [2:0] CfgNormalY = 3'd1;
	localparam logic [2:0] CfgNormalZ = 3'd2;
	localparam logic [2:0] CfgCenterX = 3'd3;
	localparam logic [2:0] CfgCenterY = 3'd4;
	localparam logic [2:0] CfgCenterZ = 3'd5;
	localparam logic [2:0] CfgWeight  = 3'd6;
	localparam logic [2:0] CfgLabel   = 3'd7;

	typedef struct packed {
		logic [IdxW-1:0]          tri_index;
		logic signed [CoordW-1:0] normal_x;
		logic signed [CoordW-1:0] normal_y;
		logic signed [CoordW-1:0] normal_z;
		logic signed [CoordW-1:0] center_x;
		logic signed [CoordW-1:0] center_y;
		logic signed [CoordW-1:0] center_z;
		logic                     first_of_pass;
		logic                     new_run;
	} in_item_t;

	typedef struct packed {
		logic [DistW-1:0]  kept_distance;
		logic [LabelW-1:0] best_label;
		logic [SumW-1:0]   cumulative_sum;
		logic              was_updated;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input item, start squares
		logic acc;        // accumulate one squared difference
		logic sqrt_init;  // start a square root
		logic sqrt_step;  // one root digit
		logic sqrt_dn;    // store root as dn
		logic sqrt_dc;    // store root as dc
		logic num;        // build numerator
		logic div_step;   // one quotient bit
		logic mem_rd;     // read stores
		logic decide;     // compare, write back, build result, part 1
		logic sum;        // update running sum
		logic out_ld;     // load the output register
	} cmd_t;
endpackage : kmpp_pkg
`default_nettype wire

// File: rtl/kmpp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmpp_datapath: arithmetic and stores
// Squares, shared iterative root and divider, per-triangle stores, sum.
// ----------------------------------------------------------------------------
module kmpp_datapath import kmpp_pkg::*; #(
	parameter int MAX_TRIANGLES = MaxTrianglesDefault,
	parameter int MAX_LABELS    = MaxLabelsDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic [2:0]        sel,     // difference select during acc
	input  wire in_item_t          in_item,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [15:0]       cfg_wdata,
	input  wire logic              clr_we,
	input  wire logic [$clog2(MAX_TRIANGLES)-1:0] clr_addr,
	output out_item_t              result
);
	localparam int AW = $clog2(MAX_TRIANGLES);
	localparam int LW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
	localparam logic [LabelW-1:0] LabelMax = LabelW'(MAX_LABELS - 1);

	logic signed [15:0] pnx_q, pny_q, pnz_q, pcx_q, pcy_q, pcz_q;
	logic [15:0] w_q;
	logic [LabelW-1:0] lab_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnx_q <= '0; pny_q <= '0; pnz_q <= 16'sd4096;
			pcx_q <= '0; pcy_q <= '0; pcz_q <= '0;
			w_q <= 16'd4096; lab_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgNormalX: pnx_q <= cfg_wdata;
				CfgNormalY: pny_q <= cfg_wdata;
				CfgNormalZ: pnz_q <= cfg_wdata;
				CfgCenterX: pcx_q <= cfg_wdata;
				CfgCenterY: pcy_q <= cfg_wdata;
				CfgCenterZ: pcz_q <= cfg_wdata;
				CfgWeight:  w_q   <= cfg_wdata;
				CfgLabel:   lab_q <= cfg_wdata[LabelW-1:0];
				default: ;
			endcase
		end
	end

	in_item_t item_q;
	logic [AW-1:0] idx_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
			idx_q  <= in_item.tri_index[AW-1:0];
		end
	end

	// one squared difference per cycle
	logic signed [16:0] da, db, diff;
	logic [16:0] mag;
	logic [33:0] sq;
	logic [35:0] acc_q;
	always_comb begin
		case (sel)
			3'd0: begin da = 17'(item_q.normal_x); db = 17'(pnx_q); end
			3'd1: begin da = 17'(item_q.normal_y); db = 17'(pny_q); end
			3'd2: begin da = 17'(item_q.normal_z); db = 17'(pnz_q); end
			3'd3: begin da = 17'(item_q.center_x); db = 17'(pcx_q); end
			3'd4: begin da = 17'(item_q.center_y); db = 17'(pcy_q); end
			default: begin da = 17'(item_q.center_z); db = 17'(pcz_q); end
		endcase
		diff = da - db;
		mag  = diff[16] ? 17'(-diff) : diff;
		sq   = 34'(mag) * 34'(mag);
	end
	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) acc_q <= '0;
		else if (cmd.acc) acc_q <= acc_q + 36'(sq);
	end

	// restoring root, 2 bits per step, 18 steps
	logic [35:0] rem_q;
	logic [17:0] root_q;
	logic [35:0] src_q;
	logic [37:0] trial;
	logic [19:0] tdiv;
	logic [37:0] rem_sh;
	always_comb begin
		rem_sh = {rem_q, src_q[35:34]};
		tdiv   = {root_q, 2'b01};
		trial  = rem_sh - 38'(tdiv);
	end
	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			rem_q <= '0; root_q <= '0; src_q <= acc_q;
		end else if (cmd.sqrt_step) begin
			src_q <= {src_q[33:0], 2'b00};
			if (!trial[37]) begin
				rem_q  <= trial[35:0];
				root_q <= {root_q[16:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[35:0];
				root_q <= {root_q[16:0], 1'b0};
			end
		end
	end

	logic [17:0] dn_q, dc_q;
	always_ff @(posedge clk) begin
		if (cmd.sqrt_dn) dn_q <= root_q;
		if (cmd.sqrt_dc) dc_q <= root_q;
	end

	// restoring divide, numerator up to 35 bits, one bit a step
	logic [34:0] quo_q;
	logic [16:0] den_q;
	logic [17:0] drem_q;
	logic [17:0] dsh;
	logic [18:0] dtr;
	always_comb begin
		dsh = {drem_q[16:0], quo_q[34]};
		dtr = {1'b0, dsh} - {2'b0, den_q};
	end
	always_ff @(posedge clk) begin
		if (cmd.num) begin
			quo_q  <= 35'({dn_q, 12'b0}) + 35'(w_q) * 35'(dc_q);
			den_q  <= 17'(w_q) + 17'd4096;
			drem_q <= '0;
		end else if (cmd.div_step) begin
			if (!dtr[18]) begin
				drem_q <= dtr[17:0];
				quo_q  <= {quo_q[33:0], 1'b1};
			end else begin
				drem_q <= dsh;
				quo_q  <= {quo_q[33:0], 1'b0};
			end
		end
	end

	// stores: initialized by clearing pass
	logic [DistW-1:0]  dist_mem [MAX_TRIANGLES];
	logic [LabelW-1:0] lab_mem  [MAX_TRIANGLES];
	logic [DistW-1:0]  rd_dist_q;
	logic [LabelW-1:0] rd_lab_q;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DistW-1:0]  wr_dist;
	logic [LabelW-1:0] wr_lab;
	logic [DistW-1:0]  d;
	logic              upd;
	logic [LabelW-1:0] lab_sat;

	always_comb begin
		d       = quo_q[DistW-1:0];
		upd     = item_q.new_run || (d < rd_dist_q);
		lab_sat = (32'(lab_q) >= 32'(MAX_LABELS)) ? LabelMax : lab_q;
		wr_en   = clr_we || (cmd.decide && upd);
		wr_addr = clr_we ? clr_addr : idx_q;
		wr_dist = clr_we ? {DistW{1'b1}} : d;
		wr_lab  = clr_we ? '0 : lab_sat;
	end
	always_ff @(posedge clk) begin
		if (wr_en) begin
			dist_mem[wr_addr] <= wr_dist;
			lab_mem[wr_addr]  <= wr_lab;
		end
		if (cmd.mem_rd) begin
			rd_dist_q <= dist_mem[idx_q];
			rd_lab_q  <= lab_mem[idx_q];
		end
	end

	logic [DistW-1:0]  kept_q;
	logic [LabelW-1:0] klab_q;
	logic              upd_q;
	logic [33:0]       ksq;
	logic [SumW-1:0]   sum_q, base;
	logic [SumW:0]     nsum;
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			kept_q <= upd ? d : rd_dist_q;
			klab_q <= upd ? lab_sat : rd_lab_q;
			upd_q  <= upd;
		end
	end
	always_comb begin
		ksq  = 34'(kept_q) * 34'(kept_q);
		base = item_q.first_of_pass ? '0 : sum_q;
		nsum = {1'b0, base} + 49'(ksq);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sum_q <= '0;
		else if (cmd.sum) sum_q <= nsum[SumW] ? {SumW{1'b1}} : nsum[SumW-1:0];
	end

	// output register: holds a waiting result while the next item runs
	out_item_t out_q;
	always_ff @(posedge clk) begin
		if (cmd.out_ld) out_q <= '{kept_distance: kept_q, best_label: klab_q,
			cumulative_sum: sum_q, was_updated: upd_q};
	end

	assign result = out_q;

	logic unused;
	assign unused = ^{item_q.tri_index, LW'(0)};
endmodule : kmpp_datapath
`default_nettype wire

// File: rtl/kmpp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmpp_ctrl: sequencer
// Clearing pass, then per item: squares, two roots, divide, store update.
// ----------------------------------------------------------------------------
module kmpp_ctrl import kmpp_pkg::*; #(
	parameter int MAX_TRIANGLES = MaxTrianglesDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output cmd_t             cmd,
	output logic [2:0]       sel,
	output logic             clr_we,
	output logic [$clog2(MAX_TRIANGLES)-1:0] clr_addr
);
	localparam int AW = $clog2(MAX_TRIANGLES);
	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_SQN = 4'd2, S_RTN = 4'd3,
		S_SQC = 4'd4, S_RTC = 4'd5, S_NUM = 4'd6, S_DIV = 4'd7, S_RD = 4'd8,
		S_DEC = 4'd9, S_SUM = 4'd10, S_OUT = 4'd11;

	logic [3:0]    state_q;
	logic [5:0]    cnt_q;
	logic [AW-1:0] clr_q;
	logic          ov_q;
	logic          in_root;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign clr_we    = (state_q == S_CLR);
	assign clr_addr  = clr_q;
	assign in_root   = (state_q == S_RTN) || (state_q == S_RTC);

	// root phase: loads the sum, runs the root steps, then stores the root
	always_comb begin
		cmd = '0;
		sel = 3'(cnt_q);
		cmd.load      = in_valid && in_ready;
		cmd.acc       = (state_q == S_SQN) || (state_q == S_SQC);
		if (state_q == S_SQC) sel = 3'(cnt_q + 6'd3);
		cmd.sqrt_init = cmd.load || (in_root && cnt_q == 6'd0);
		cmd.sqrt_step = in_root && cnt_q != 6'd0 && cnt_q <= 6'd18;
		cmd.sqrt_dn   = (state_q == S_RTN) && cnt_q == 6'd19;
		cmd.sqrt_dc   = (state_q == S_RTC) && cnt_q == 6'd19;
		cmd.num       = (state_q == S_NUM);
		cmd.div_step  = (state_q == S_DIV);
		cmd.mem_rd    = (state_q == S_RD);
		cmd.decide    = (state_q == S_DEC);
		cmd.sum       = (state_q == S_SUM);
		cmd.out_ld    = (state_q == S_OUT) && (!ov_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; cnt_q <= '0; clr_q <= '0; ov_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == MAX_TRIANGLES - 1) state_q <= S_IDLE;
				end
				S_IDLE: if (cmd.load) begin state_q <= S_SQN; cnt_q <= '0; end
				S_SQN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd2) begin state_q <= S_RTN; cnt_q <= '0; end
				end
				S_RTN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd19) begin state_q <= S_SQC; cnt_q <= '0; end
				end
				S_SQC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd2) begin state_q <= S_RTC; cnt_q <= '0; end
				end
				S_RTC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd19) begin state_q <= S_NUM; cnt_q <= '0; end
				end
				S_NUM: state_q <= S_DIV;
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd34) begin state_q <= S_RD; cnt_q <= '0; end
				end
				S_RD:  state_q <= S_DEC;
				S_DEC: state_q <= S_SUM;
				S_SUM: state_q <= S_OUT;
				S_OUT: if (cmd.out_ld) begin ov_q <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule : kmpp_ctrl
`default_nettype wire

// File: rtl/kmeanspp_plane_distance_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmeanspp_plane_distance_update: k-means++ plane distance step
// One triangle in, one result out; per-triangle minimum and label kept.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one triangle transaction; out_valid/out_ready
//   carry one result transaction per triangle. Configuration writes through
//   cfg_we/cfg_index/cfg_wdata are for the user to make only while the block is idle; the block does not enforce it.
// Sequence: an input transaction is followed by three squares and a root
//   pass (load, 18 steps, store) for each norm, both through the one
//   shared root unit, one numerator build, a 35-step restoring divider, a
//   store read, compare/write-back, sum update and the output register
//   load that raises out_valid.
// Overlap: a new triangle is accepted only after the previous one has
//   reached the output register, as the root unit and divider are shared.
// Reset: a clearing pass writes infinite distance and label zero into
//   every store entry; in_ready stays low meanwhile.
// Stall: a result waits in the output register while out_ready is low;
//   the next triangle is accepted meanwhile, but its result is held back
//   until the prior transaction is taken.
// ----------------------------------------------------------------------------
module kmeanspp_plane_distance_update import kmpp_pkg::*; #(
	parameter int MAX_TRIANGLES = MaxTrianglesDefault,
	parameter int MAX_LABELS    = MaxLabelsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	cmd_t cmd;
	logic [2:0] sel;
	logic clr_we;
	logic [$clog2(MAX_TRIANGLES)-1:0] clr_addr;

	// sequencer
	kmpp_ctrl #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.cmd, .sel, .clr_we, .clr_addr
	);

	// arithmetic and stores
	kmpp_datapath #(.MAX_TRIANGLES(MAX_TRIANGLES), .MAX_LABELS(MAX_LABELS)) u_dp (
		.clk, .arst_n, .cmd, .sel, .in_item(in_data),
		.cfg_we, .cfg_index, .cfg_wdata, .clr_we, .clr_addr, .result(out_data)
	);
endmodule : kmeanspp_plane_distance_update
`default_nettype wire

// File: rtl/kmpp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmpp_checker: port-level checks
// Observes the top-level ports only.
// ----------------------------------------------------------------------------
module kmpp_checker import kmpp_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);
	// a result held back holds its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// input taken never results in a result the next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");
	// a valid result carries a label below 64
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.best_label) < 64)
		else $error("label out of range");
	// not ready as reset is released and clearing starts
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !in_ready)
		else $error("ready during clearing");
endmodule : kmpp_checker

bind kmeanspp_plane_distance_update kmpp_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
